// ===== rtl/core/wst_pkg.sv =====
// Shared types and constants for the watchpoint slot table.
`timescale 1ns / 1ps
package wst_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CFG_W = 4;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam int ADDR_W = 32;
  localparam int TYPE_W = 3;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 3;
  localparam int ACT_W  = 2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_QUERY  = 3'd2,
    KIND_ACT    = 3'd3,
    KIND_DEACT  = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 2'd0,
    ACT_PROG   = 2'd1,
    ACT_UNPROG = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    SS_UNDEF   = 2'd0,
    SS_REMOVED = 2'd1,
    SS_SET     = 2'd2,
    SS_ACTIVE  = 2'd3
  } slot_state_e;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    slot_state_e       state;
    logic              payload_en;
    logic [ADDR_W-1:0] addr;
    logic [TYPE_W-1:0] wtype;
  } wr_t;

  typedef struct packed {
    logic              status;
    logic              is_removed;
    action_e           action;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] slot_addr;
    logic [TYPE_W-1:0] slot_type;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/watchpoint_slot_table.sv =====
// Watchpoint slot table: one address comparator visits one slot per cycle over n slots,
// n = slots_in_use capped at 8, except that an activate, deactivate or clear walk holds
// while its result side stalls. A command is taken in idle and walks its n slots; its last
// result is then registered at the output (unknown kinds skip the walk). No new command is
// taken until that last result is registered. Reset is asynchronous and active low: every
// slot becomes undefined, slots_in_use becomes 0, and the block leaves reset ready for a command.
`timescale 1ns / 1ps
module watchpoint_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // addr[31:0], watch_type[34:32], zero fill
  input  logic [wst_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind[2:0]
  input  logic [wst_pkg::KIND_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status[0], is_removed[1], slot[4:2], slot_addr[36:5], slot_type[39:37]
  output logic [wst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // action[1:0]
  output logic [wst_pkg::ACT_W-1:0]      m_axis_tuser_o,
  output logic                           m_axis_tlast_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wst_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [wst_pkg::APB_DATA_W-1:0] pwdata,
  output logic [wst_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [wst_pkg::CFG_W-1:0]  slots_in_use_q;
  logic [wst_pkg::IDX_W-1:0]  rd_idx;
  wst_pkg::slot_state_e       rd_state;
  logic [wst_pkg::ADDR_W-1:0] rd_addr;
  logic [wst_pkg::TYPE_W-1:0] rd_type;
  wst_pkg::wr_t               wr;
  wst_pkg::res_t              res;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == wst_pkg::REG_SLOTS_IN_USE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      slots_in_use_q <= pwdata[wst_pkg::CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? wst_pkg::APB_DATA_W'(slots_in_use_q) : '0;

  wst_slot_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (rd_idx),
    .rd_state_o (rd_state),
    .rd_addr_o  (rd_addr),
    .rd_type_o  (rd_type),
    .wr_i       (wr)
  );

  wst_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .slots_in_use_i (slots_in_use_q),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_kind_i      (s_axis_tuser_i),
    .in_addr_i      (s_axis_tdata_i[31:0]),
    .in_type_i      (s_axis_tdata_i[34:32]),
    .rd_idx_o       (rd_idx),
    .rd_state_i     (rd_state),
    .rd_addr_i      (rd_addr),
    .rd_type_i      (rd_type),
    .wr_o           (wr),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_res_o      (res)
  );

  assign m_axis_tdata_o = {res.slot_type, res.slot_addr, res.slot, res.is_removed, res.status};
  assign m_axis_tuser_o = res.action;
  assign m_axis_tlast_o = res.last;

endmodule

// ===== rtl/core/wst_slot_store.sv =====
// Slot state, address and type registers with one read and one write port.
`timescale 1ns / 1ps
module wst_slot_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wst_pkg::IDX_W-1:0]  rd_idx_i,
  output wst_pkg::slot_state_e       rd_state_o,
  output logic [wst_pkg::ADDR_W-1:0] rd_addr_o,
  output logic [wst_pkg::TYPE_W-1:0] rd_type_o,
  input  wst_pkg::wr_t               wr_i
);

  wst_pkg::slot_state_e       state_q [wst_pkg::SLOTS];
  logic [wst_pkg::ADDR_W-1:0] addr_q  [wst_pkg::SLOTS];
  logic [wst_pkg::TYPE_W-1:0] type_q  [wst_pkg::SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wst_pkg::SLOTS; i++) begin
        state_q[i] <= wst_pkg::SS_UNDEF;
      end
    end else if (wr_i.en) begin
      state_q[wr_i.idx] <= wr_i.state;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.payload_en) begin
      addr_q[wr_i.idx] <= wr_i.addr;
      type_q[wr_i.idx] <= wr_i.wtype;
    end
  end

  assign rd_state_o = state_q[rd_idx_i];
  assign rd_addr_o  = addr_q[rd_idx_i];
  assign rd_type_o  = type_q[rd_idx_i];

endmodule

// ===== rtl/core/wst_seq.sv =====
// Command sequencer: walks slots one per cycle unless stalled; shared comparator.
`timescale 1ns / 1ps
module wst_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wst_pkg::CFG_W-1:0]  slots_in_use_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [wst_pkg::KIND_W-1:0] in_kind_i,
  input  logic [wst_pkg::ADDR_W-1:0] in_addr_i,
  input  logic [wst_pkg::TYPE_W-1:0] in_type_i,
  output logic [wst_pkg::IDX_W-1:0]  rd_idx_o,
  input  wst_pkg::slot_state_e       rd_state_i,
  input  logic [wst_pkg::ADDR_W-1:0] rd_addr_i,
  input  logic [wst_pkg::TYPE_W-1:0] rd_type_i,
  output wst_pkg::wr_t               wr_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output wst_pkg::res_t              out_res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_e;

  seq_state_e                 state_q, state_d;
  wst_pkg::kind_e             kind_q, kind_d;
  logic [wst_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [wst_pkg::TYPE_W-1:0] wtype_q, wtype_d;
  logic [wst_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [wst_pkg::CNT_W-1:0]  n_q, n_d;
  logic                       found_q, found_d;
  logic                       rem_valid_q, rem_valid_d;
  logic [wst_pkg::IDX_W-1:0]  rem_idx_q, rem_idx_d;
  logic                       undef_valid_q, undef_valid_d;
  logic [wst_pkg::IDX_W-1:0]  undef_idx_q, undef_idx_d;
  logic                       pend_valid_q, pend_valid_d;
  wst_pkg::res_t              pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  wst_pkg::res_t              res_q, res_d;

  logic [wst_pkg::CNT_W-1:0]  n_live;
  logic [wst_pkg::IDX_W-1:0]  idx;
  logic                       addr_eq;
  logic                       out_free;
  logic                       push;
  wst_pkg::res_t              push_res;
  logic                       walk_emit;
  logic                       walk_wen;
  wst_pkg::slot_state_e       walk_state;
  wst_pkg::action_e           walk_act;
  logic                       pick_ok;

  assign n_live = (wst_pkg::CMP_W'(slots_in_use_i) > wst_pkg::CMP_W'(wst_pkg::SLOTS)) ?
                  wst_pkg::CNT_W'(wst_pkg::SLOTS) : wst_pkg::CNT_W'(slots_in_use_i);
  assign idx      = cnt_q[wst_pkg::IDX_W-1:0];
  assign addr_eq  = (rd_addr_i == addr_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign pick_ok  = !found_q && (rem_valid_q || undef_valid_q);

  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    addr_d        = addr_q;
    wtype_d       = wtype_q;
    cnt_d         = cnt_q;
    n_d           = n_q;
    found_d       = found_q;
    rem_valid_d   = rem_valid_q;
    rem_idx_d     = rem_idx_q;
    undef_valid_d = undef_valid_q;
    undef_idx_d   = undef_idx_q;
    pend_valid_d  = pend_valid_q;
    pend_d        = pend_q;
    wr_o          = '0;
    push          = 1'b0;
    push_res      = '0;
    walk_emit     = 1'b0;
    walk_wen      = 1'b0;
    walk_state    = wst_pkg::SS_UNDEF;
    walk_act      = wst_pkg::ACT_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d        = wst_pkg::kind_e'(in_kind_i);
          addr_d        = in_addr_i;
          wtype_d       = in_type_i;
          cnt_d         = '0;
          n_d           = n_live;
          found_d       = 1'b0;
          rem_valid_d   = 1'b0;
          undef_valid_d = 1'b0;
          pend_valid_d  = 1'b0;
          state_d = (in_kind_i <= wst_pkg::KIND_CLEAR) ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (cnt_q == n_q) begin
          state_d = S_FINISH;
        end else begin
          case (kind_q)
            wst_pkg::KIND_SET: begin
              if (rd_state_i == wst_pkg::SS_SET && addr_eq) found_d = 1'b1;
              if (rd_state_i == wst_pkg::SS_REMOVED && !rem_valid_q) begin
                rem_valid_d = 1'b1;
                rem_idx_d   = idx;
              end
              if (rd_state_i == wst_pkg::SS_UNDEF && !undef_valid_q) begin
                undef_valid_d = 1'b1;
                undef_idx_d   = idx;
              end
              cnt_d = cnt_q + 1'b1;
            end
            wst_pkg::KIND_REMOVE: begin
              if (!found_q && rd_state_i == wst_pkg::SS_SET && addr_eq) begin
                found_d   = 1'b1;
                wr_o.en    = 1'b1;
                wr_o.idx   = idx;
                wr_o.state = wst_pkg::SS_REMOVED;
              end
              cnt_d = cnt_q + 1'b1;
            end
            wst_pkg::KIND_QUERY: begin
              if (rd_state_i == wst_pkg::SS_REMOVED && addr_eq) found_d = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
            default: begin
              case (kind_q)
                wst_pkg::KIND_ACT: begin
                  walk_emit  = (rd_state_i == wst_pkg::SS_SET);
                  walk_wen   = walk_emit;
                  walk_state = wst_pkg::SS_ACTIVE;
                  walk_act   = wst_pkg::ACT_PROG;
                end
                wst_pkg::KIND_DEACT: begin
                  walk_emit  = (rd_state_i == wst_pkg::SS_ACTIVE);
                  walk_wen   = walk_emit;
                  walk_state = wst_pkg::SS_SET;
                  walk_act   = wst_pkg::ACT_UNPROG;
                end
                default: begin
                  walk_emit  = (rd_state_i == wst_pkg::SS_ACTIVE);
                  walk_wen   = 1'b1;
                  walk_state = wst_pkg::SS_UNDEF;
                  walk_act   = wst_pkg::ACT_UNPROG;
                end
              endcase
              if (!(walk_emit && pend_valid_q && !out_free)) begin
                if (walk_emit) begin
                  if (pend_valid_q) begin
                    push     = 1'b1;
                    push_res = pend_q;
                  end
                  pend_valid_d     = 1'b1;
                  pend_d           = '0;
                  pend_d.action    = walk_act;
                  pend_d.slot      = wst_pkg::SLOT_W'(idx);
                  pend_d.slot_addr = rd_addr_i;
                  pend_d.slot_type = rd_type_i;
                end
                wr_o.en    = walk_wen;
                wr_o.idx   = idx;
                wr_o.state = walk_state;
                cnt_d      = cnt_q + 1'b1;
              end
            end
          endcase
        end
      end
      S_FINISH: begin
        if (out_free) begin
          push          = 1'b1;
          push_res.last = 1'b1;
          state_d       = S_IDLE;
          case (kind_q) inside
            wst_pkg::KIND_SET: begin
              push_res.status = !found_q && !rem_valid_q && !undef_valid_q;
              wr_o.en         = pick_ok;
              wr_o.payload_en = pick_ok;
              wr_o.idx        = rem_valid_q ? rem_idx_q : undef_idx_q;
              wr_o.state      = wst_pkg::SS_SET;
              wr_o.addr       = addr_q;
              wr_o.wtype      = wtype_q;
            end
            wst_pkg::KIND_REMOVE: push_res.status = !found_q;
            wst_pkg::KIND_QUERY:  push_res.is_removed = found_q;
            wst_pkg::KIND_ACT, wst_pkg::KIND_DEACT, wst_pkg::KIND_CLEAR: begin
              if (pend_valid_q) begin
                push_res      = pend_q;
                push_res.last = 1'b1;
              end
            end
            default: push_res.status = 1'b1;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push) begin
      out_valid_d = 1'b1;
      res_d       = push_res;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
      res_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kind_q        <= wst_pkg::KIND_SET;
      addr_q        <= '0;
      wtype_q       <= '0;
      cnt_q         <= '0;
      n_q           <= '0;
      found_q       <= 1'b0;
      rem_valid_q   <= 1'b0;
      rem_idx_q     <= '0;
      undef_valid_q <= 1'b0;
      undef_idx_q   <= '0;
      pend_valid_q  <= 1'b0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
      res_q         <= '0;
    end else begin
      state_q       <= state_d;
      kind_q        <= kind_d;
      addr_q        <= addr_d;
      wtype_q       <= wtype_d;
      cnt_q         <= cnt_d;
      n_q           <= n_d;
      found_q       <= found_d;
      rem_valid_q   <= rem_valid_d;
      rem_idx_q     <= rem_idx_d;
      undef_valid_q <= undef_valid_d;
      undef_idx_q   <= undef_idx_d;
      pend_valid_q  <= pend_valid_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
      res_q         <= res_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign rd_idx_o    = idx;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/core/wst_checker.sv =====
// Port-level checks for the watchpoint slot table, bound to the top level.
`timescale 1ns / 1ps
module wst_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [wst_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [wst_pkg::ACT_W-1:0]      m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result transfer dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken while previous command still running");

  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("command taken before the last result of a run");

  a_plain_result_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == wst_pkg::ACT_NONE
      |-> m_axis_tdata_o[39:2] == '0 && m_axis_tlast_o)
    else $error("result without slot action carries slot fields");

  a_removed_only_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1]
      |-> m_axis_tuser_o == wst_pkg::ACT_NONE && !m_axis_tdata_o[0])
    else $error("query answer mixed with status or action");

endmodule

bind watchpoint_slot_table wst_checker u_wst_checker (.*);
